@@ hw/rtl/cwtmc_pkg.sv @@
// shared types, codes and reset constants of the cw trainer mode controller
`timescale 1ns / 1ps

package cwtmc_pkg;

    // key event codes
    localparam logic [1:0] KEY_NONE    = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_UP      = 2'd2;
    localparam logic [1:0] KEY_LONG_UP = 2'd3;

    // sender action codes
    localparam logic [1:0] ACT_HOLD        = 2'd0;
    localparam logic [1:0] ACT_FINISHED    = 2'd1;
    localparam logic [1:0] ACT_START_MARK  = 2'd2;
    localparam logic [1:0] ACT_START_SPACE = 2'd3;

    // sender command codes
    localparam logic [2:0] CMD_NONE            = 3'd0;
    localparam logic [2:0] CMD_ANNOUNCE_S      = 3'd1;
    localparam logic [2:0] CMD_ANNOUNCE_P      = 3'd2;
    localparam logic [2:0] CMD_RESET           = 3'd3;
    localparam logic [2:0] CMD_NEW_GROUP       = 3'd4;
    localparam logic [2:0] CMD_RESET_NEW_GROUP = 3'd5;
    localparam logic [2:0] CMD_REWIND          = 3'd6;
    localparam logic [2:0] CMD_FLUSH           = 3'd7;

    // capture push codes
    localparam logic [1:0] PUSH_NONE  = 2'd0;
    localparam logic [1:0] PUSH_MARK  = 2'd1;
    localparam logic [1:0] PUSH_SPACE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_SPACING = 2'd0;
    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
    localparam logic [1:0] REG_MIN_CHARS   = 2'd2;
    localparam logic [1:0] REG_MAX_CHARS   = 2'd3;

    // register reset values
    localparam logic [3:0] RST_MAX_SPACING  = 4'd6;
    localparam logic [2:0] RST_MAX_ATTEMPTS = 3'd3;
    localparam logic [2:0] RST_MIN_CHARS    = 3'd2;
    localparam logic [2:0] RST_MAX_CHARS    = 3'd5;

    typedef enum logic
    {
        S_ANNOUNCE,
        S_MIRROR
    } straight_phase_t;

    typedef enum logic [1:0]
    {
        P_ANNOUNCE,
        P_SENDING,
        P_WAITING
    } practice_phase_t;

    typedef struct packed
    {
        logic [1:0] key_event;
        logic [1:0] sender_action;
        logic       echo_matched;
        logic       echo_timed_out;
    } cwtmc_in_t;

    typedef struct packed
    {
        logic        tone_on;
        logic [2:0]  sender_cmd;
        logic        capture_clear_before;
        logic        capture_advance;
        logic [1:0]  capture_push;
        logic        capture_clear_after;
        logic [2:0]  group_chars;
        logic [3:0]  group_spacing;
        logic [15:0] random_seed;
        logic        in_practice;
    } cwtmc_out_t;

endpackage

@@ hw/rtl/cw_trainer_mode_controller.sv @@
// cw trainer mode controller: per-tick mode, grading and sender/capture commands
// latency: the result of a tick is valid in the cycle after its input beat
// throughput: one tick per cycle; next state is a single pass of logic from the input beat
// the output register is the only buffer: a new beat is taken while out_ready is high or
// the register is empty
// reset: straight-key mode announcing, tone off, registers at their defaults, no result held
`timescale 1ns / 1ps

module cw_trainer_mode_controller
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cwtmc_pkg::cwtmc_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cwtmc_pkg::cwtmc_out_t  out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [3:0]             cfg_data
);
    import cwtmc_pkg::*;

    logic [3:0]      max_spacing_reg;
    logic [2:0]      max_attempts_reg;
    logic [2:0]      min_chars_reg;
    logic [2:0]      max_chars_reg;

    logic            practice_mode_reg;
    logic            practice_mode_next;
    straight_phase_t straight_phase_reg;
    straight_phase_t straight_phase_next;
    practice_phase_t practice_phase_reg;
    practice_phase_t practice_phase_next;
    logic [2:0]      char_count_reg;
    logic [2:0]      char_count_next;
    logic [3:0]      spacing_reg;
    logic [3:0]      spacing_next;
    logic [2:0]      attempt_reg;
    logic [2:0]      attempt_next;
    logic [15:0]     tick_reg;
    logic [15:0]     tick_next;
    logic            tone_reg;
    logic            tone_next;

    logic            out_valid_reg;
    cwtmc_out_t      result_reg;
    cwtmc_out_t      result_next;

    logic            in_fire;
    logic            long_rel;
    logic            key_any;
    logic            send_done;
    logic            wait_now;
    logic            grade;
    logic            pass_path;

    logic [2:0]      cmd;
    logic            clr_b;
    logic            adv;
    logic [1:0]      push;
    logic            clr_a;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    // decode of the tick
    always_comb
    begin
        long_rel  = (in_data.key_event == KEY_LONG_UP);
        key_any   = (in_data.key_event != KEY_NONE);
        send_done = (in_data.sender_action == ACT_FINISHED);
        wait_now  = 1'b0;
        if (practice_mode_reg && !long_rel)
        begin
            unique case (practice_phase_reg)
                P_ANNOUNCE: wait_now = 1'b0;
                P_SENDING:  wait_now = key_any;
                default:    wait_now = 1'b1;
            endcase
        end
        grade     = wait_now && !key_any && in_data.echo_timed_out;
        pass_path = in_data.echo_matched || (attempt_reg >= max_attempts_reg);
    end

    // next state of mode and phases
    always_comb
    begin
        practice_mode_next  = practice_mode_reg;
        straight_phase_next = straight_phase_reg;
        practice_phase_next = practice_phase_reg;
        if (long_rel)
        begin
            practice_mode_next = !practice_mode_reg;
            if (!practice_mode_reg)
            begin
                practice_phase_next = P_ANNOUNCE;
            end
            else
            begin
                straight_phase_next = S_ANNOUNCE;
            end
        end
        else if (!practice_mode_reg)
        begin
            if (straight_phase_reg == S_ANNOUNCE && (key_any || send_done))
            begin
                straight_phase_next = S_MIRROR;
            end
        end
        else
        begin
            unique case (practice_phase_reg)
                P_ANNOUNCE:
                begin
                    if (key_any || send_done)
                    begin
                        practice_phase_next = P_SENDING;
                    end
                end
                P_SENDING:
                begin
                    if (key_any || send_done)
                    begin
                        practice_phase_next = P_WAITING;
                    end
                end
                default:
                begin
                    if (grade)
                    begin
                        practice_phase_next = P_SENDING;
                    end
                end
            endcase
        end
    end

    // commands to the sender and the capture unit
    always_comb
    begin
        cmd   = CMD_NONE;
        clr_b = 1'b0;
        adv   = 1'b0;
        push  = PUSH_NONE;
        clr_a = 1'b0;
        if (long_rel)
        begin
            clr_b = 1'b1;
            cmd   = practice_mode_reg ? CMD_ANNOUNCE_S : CMD_ANNOUNCE_P;
        end
        else if (!practice_mode_reg)
        begin
            if (straight_phase_reg == S_ANNOUNCE && key_any)
            begin
                cmd = CMD_RESET;
            end
        end
        else
        begin
            unique case (practice_phase_reg)
                P_ANNOUNCE:
                begin
                    if (key_any)
                    begin
                        cmd   = CMD_RESET_NEW_GROUP;
                        clr_b = 1'b1;
                    end
                    else if (send_done)
                    begin
                        cmd   = CMD_NEW_GROUP;
                        clr_b = 1'b1;
                    end
                end
                P_SENDING:
                begin
                    if (key_any)
                    begin
                        cmd   = CMD_FLUSH;
                        clr_b = 1'b1;
                    end
                    else if (send_done)
                    begin
                        clr_b = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (wait_now)
            begin
                adv = 1'b1;
                if (in_data.key_event == KEY_PRESS)
                begin
                    push = PUSH_SPACE;
                end
                else if (in_data.key_event == KEY_UP)
                begin
                    push = PUSH_MARK;
                end
                else if (grade)
                begin
                    clr_a = 1'b1;
                    cmd   = pass_path ? CMD_NEW_GROUP : CMD_REWIND;
                end
            end
        end
    end

    // tone, difficulty and counters
    always_comb
    begin
        tick_next       = tick_reg + 16'd1;
        tone_next       = tone_reg;
        char_count_next = char_count_reg;
        spacing_next    = spacing_reg;
        attempt_next    = attempt_reg;

        // tone effect of the sender while announcing or sending
        if (!long_rel && !key_any &&
            ((!practice_mode_reg && straight_phase_reg == S_ANNOUNCE) ||
             (practice_mode_reg &&
              (practice_phase_reg == P_ANNOUNCE || practice_phase_reg == P_SENDING))))
        begin
            case (in_data.sender_action)
                ACT_FINISHED:    tone_next = 1'b0;
                ACT_START_MARK:  tone_next = 1'b1;
                ACT_START_SPACE: tone_next = 1'b0;
                default:         tone_next = tone_reg;
            endcase
        end

        if (long_rel)
        begin
            tone_next       = 1'b0;
            attempt_next    = 3'd0;
            char_count_next = min_chars_reg;
            spacing_next    = max_spacing_reg;
        end
        else if (!practice_mode_reg)
        begin
            // key mirrored once announcing is over, also on the tick that ends it
            if (in_data.key_event == KEY_PRESS)
            begin
                tone_next = 1'b1;
            end
            else if (in_data.key_event == KEY_UP)
            begin
                tone_next = 1'b0;
            end
        end
        else
        begin
            if (practice_phase_reg == P_ANNOUNCE && key_any)
            begin
                tone_next = 1'b0;
            end
            if (wait_now)
            begin
                if (in_data.key_event == KEY_PRESS)
                begin
                    tone_next = 1'b1;
                end
                else if (in_data.key_event == KEY_UP || grade)
                begin
                    tone_next = 1'b0;
                end
            end
            if (grade)
            begin
                if (pass_path && (attempt_reg < max_attempts_reg))
                begin
                    // harder: cut spacing, then add a character
                    if (spacing_reg != 4'd0)
                    begin
                        spacing_next = spacing_reg - 4'd1;
                    end
                    else if (char_count_reg < max_chars_reg)
                    begin
                        char_count_next = char_count_reg + 3'd1;
                        spacing_next    = max_spacing_reg;
                    end
                end
                else
                begin
                    // easier: widen spacing, then drop a character
                    if (spacing_reg < max_spacing_reg)
                    begin
                        spacing_next = spacing_reg + 4'd1;
                    end
                    else if (char_count_reg > min_chars_reg)
                    begin
                        char_count_next = char_count_reg - 3'd1;
                        spacing_next    = 4'd0;
                    end
                end
                attempt_next = pass_path ? 3'd0 : (attempt_reg + 3'd1);
            end
        end
    end

    always_comb
    begin
        result_next.tone_on              = tone_next;
        result_next.sender_cmd           = cmd;
        result_next.capture_clear_before = clr_b;
        result_next.capture_advance      = adv;
        result_next.capture_push         = push;
        result_next.capture_clear_after  = clr_a;
        result_next.in_practice          = practice_mode_next;
        if (cmd == CMD_NEW_GROUP || cmd == CMD_RESET_NEW_GROUP)
        begin
            result_next.group_chars   = char_count_next;
            result_next.group_spacing = spacing_next;
        end
        else
        begin
            result_next.group_chars   = 3'd0;
            result_next.group_spacing = 4'd0;
        end
        result_next.random_seed = (cmd == CMD_ANNOUNCE_P) ? tick_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_spacing_reg  <= RST_MAX_SPACING;
            max_attempts_reg <= RST_MAX_ATTEMPTS;
            min_chars_reg    <= RST_MIN_CHARS;
            max_chars_reg    <= RST_MAX_CHARS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_SPACING:  max_spacing_reg  <= cfg_data;
                REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[2:0];
                REG_MIN_CHARS:    min_chars_reg    <= cfg_data[2:0];
                REG_MAX_CHARS:    max_chars_reg    <= cfg_data[2:0];
                default:          max_chars_reg    <= max_chars_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            practice_mode_reg  <= 1'b0;
            straight_phase_reg <= S_ANNOUNCE;
            practice_phase_reg <= P_ANNOUNCE;
            char_count_reg     <= RST_MIN_CHARS;
            spacing_reg        <= RST_MAX_SPACING;
            attempt_reg        <= 3'd0;
            tick_reg           <= 16'd0;
            tone_reg           <= 1'b0;
        end
        else if (in_fire)
        begin
            practice_mode_reg  <= practice_mode_next;
            straight_phase_reg <= straight_phase_next;
            practice_phase_reg <= practice_phase_next;
            char_count_reg     <= char_count_next;
            spacing_reg        <= spacing_next;
            attempt_reg        <= attempt_next;
            tick_reg           <= tick_next;
            tone_reg           <= tone_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    // every input beat leaves a result behind
    a_result_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("no result after an input beat");

    // group difficulty only travels with a new group command
    a_group_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.sender_cmd != CMD_NEW_GROUP
            && result_reg.sender_cmd != CMD_RESET_NEW_GROUP
        |-> result_reg.group_chars == 3'd0 && result_reg.group_spacing == 4'd0)
        else $error("group fields set without a new group command");

    // seed only handed out when practice is announced
    a_seed_only_on_practice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.sender_cmd != CMD_ANNOUNCE_P
        |-> result_reg.random_seed == 16'd0)
        else $error("seed given outside practice announcement");

    // tick count moves by one on every beat
    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> tick_reg == 16'($past(tick_reg) + 16'd1))
        else $error("tick count did not advance on a beat");
`endif

endmodule

@@ bench/cw_trainer_mode_controller_tb.sv @@
// self-checking testbench of the cw trainer mode controller
`timescale 1ns / 1ps

module cw_trainer_mode_controller_tb;

    import cwtmc_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    cwtmc_in_t   in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    cwtmc_out_t  out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    cw_trainer_mode_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller mirror: registers and state as they stand after reset
    logic [3:0]      cfg_max_spacing  = RST_MAX_SPACING;
    logic [2:0]      cfg_max_attempts = RST_MAX_ATTEMPTS;
    logic [2:0]      cfg_min_chars    = RST_MIN_CHARS;
    logic [2:0]      cfg_max_chars    = RST_MAX_CHARS;
    logic            practice_on      = 1'b0;
    straight_phase_t s_phase          = S_ANNOUNCE;
    practice_phase_t p_phase          = P_ANNOUNCE;
    logic [2:0]      chars_now        = RST_MIN_CHARS;
    logic [3:0]      spacing_now      = RST_MAX_SPACING;
    logic [2:0]      attempts_used    = '0;
    logic [15:0]     ticks            = '0;
    logic            tone_now         = 1'b0;

    cwtmc_out_t      tick_results_due[$];
    int              mismatches = 0;
    int              idle_cycles = 0;
    int              burst_left = 1;
    bit              valid_hi = 1'b0;
    int              stall_mode = 0;
    int              stall_run = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // tone effect of a sender action, true once sending has finished
    function automatic bit sender_finished(logic [1:0] act);
        case (act)
            ACT_FINISHED:
            begin
                tone_now = 1'b0;
                return 1'b1;
            end
            ACT_START_MARK:  tone_now = 1'b1;
            ACT_START_SPACE: tone_now = 1'b0;
            default:         ;
        endcase
        return 1'b0;
    endfunction

    function automatic void ease_off();
        if (spacing_now < cfg_max_spacing)
            spacing_now = spacing_now + 4'd1;
        else if (chars_now > cfg_min_chars)
        begin
            chars_now = chars_now - 3'd1;
            spacing_now = '0;
        end
    endfunction

    function automatic cwtmc_out_t advance_controller(cwtmc_in_t t);
        cwtmc_out_t r;
        logic       waiting;
        r = '0;
        ticks = ticks + 16'd1;
        if (t.key_event == KEY_LONG_UP)
        begin
            tone_now = 1'b0;
            r.capture_clear_before = 1'b1;
            attempts_used = '0;
            chars_now = cfg_min_chars;
            spacing_now = cfg_max_spacing;
            practice_on = !practice_on;
            if (practice_on)
            begin
                r.sender_cmd = CMD_ANNOUNCE_P;
                r.random_seed = ticks;
                p_phase = P_ANNOUNCE;
            end
            else
            begin
                r.sender_cmd = CMD_ANNOUNCE_S;
                s_phase = S_ANNOUNCE;
            end
        end
        else if (!practice_on)
        begin
            if (s_phase == S_ANNOUNCE)
            begin
                if (t.key_event != KEY_NONE)
                begin
                    r.sender_cmd = CMD_RESET;
                    s_phase = S_MIRROR;
                end
                else if (sender_finished(t.sender_action))
                    s_phase = S_MIRROR;
            end
            if (s_phase == S_MIRROR)
            begin
                if (t.key_event == KEY_PRESS)
                    tone_now = 1'b1;
                else if (t.key_event == KEY_UP)
                    tone_now = 1'b0;
            end
        end
        else if (p_phase == P_ANNOUNCE)
        begin
            if (t.key_event != KEY_NONE)
            begin
                tone_now = 1'b0;
                r.sender_cmd = CMD_RESET_NEW_GROUP;
                r.capture_clear_before = 1'b1;
                p_phase = P_SENDING;
            end
            else if (sender_finished(t.sender_action))
            begin
                tone_now = 1'b0;
                r.sender_cmd = CMD_NEW_GROUP;
                r.capture_clear_before = 1'b1;
                p_phase = P_SENDING;
            end
        end
        else
        begin
            waiting = (p_phase != P_SENDING);
            if (p_phase == P_SENDING)
            begin
                if (t.key_event != KEY_NONE)
                begin
                    // user keys over the group: flush and go straight to the echo
                    r.sender_cmd = CMD_FLUSH;
                    r.capture_clear_before = 1'b1;
                    p_phase = P_WAITING;
                    waiting = 1'b1;
                end
                else if (sender_finished(t.sender_action))
                begin
                    r.capture_clear_before = 1'b1;
                    p_phase = P_WAITING;
                end
            end
            if (waiting)
            begin
                r.capture_advance = 1'b1;
                if (t.key_event == KEY_PRESS)
                begin
                    tone_now = 1'b1;
                    r.capture_push = PUSH_SPACE;
                end
                else if (t.key_event == KEY_UP)
                begin
                    tone_now = 1'b0;
                    r.capture_push = PUSH_MARK;
                end
                else if (t.key_event == KEY_NONE && t.echo_timed_out)
                begin
                    tone_now = 1'b0;
                    r.capture_clear_after = 1'b1;
                    p_phase = P_SENDING;
                    if (t.echo_matched || attempts_used >= cfg_max_attempts)
                    begin
                        if (attempts_used < cfg_max_attempts)
                        begin
                            // pass: tighten spacing first, then lengthen the group
                            if (spacing_now > 4'd0)
                                spacing_now = spacing_now - 4'd1;
                            else if (chars_now < cfg_max_chars)
                            begin
                                chars_now = chars_now + 3'd1;
                                spacing_now = cfg_max_spacing;
                            end
                        end
                        else
                            ease_off();
                        attempts_used = '0;
                        r.sender_cmd = CMD_NEW_GROUP;
                    end
                    else
                    begin
                        ease_off();
                        attempts_used = attempts_used + 3'd1;
                        r.sender_cmd = CMD_REWIND;
                    end
                end
            end
        end
        if (r.sender_cmd == CMD_NEW_GROUP || r.sender_cmd == CMD_RESET_NEW_GROUP)
        begin
            r.group_chars = chars_now;
            r.group_spacing = spacing_now;
        end
        r.tone_on = tone_now;
        r.in_practice = practice_on;
        return r;
    endfunction

    function automatic cwtmc_in_t tick_of(logic [1:0] key, logic [1:0] act, logic matched,
                                          logic timed_out);
        cwtmc_in_t t;
        t.key_event = key;
        t.sender_action = act;
        t.echo_matched = matched;
        t.echo_timed_out = timed_out;
        return t;
    endfunction

    // mostly plausible ticks for the current phase, some noise
    function automatic cwtmc_in_t gen_tick(bit toggles);
        cwtmc_in_t t;
        int        roll;
        int        pick;
        t.key_event = KEY_NONE;
        t.sender_action = 2'($urandom_range(0, 3));
        t.echo_matched = 1'($urandom_range(0, 1));
        t.echo_timed_out = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 999);
        if (toggles && roll < 6)
            t.key_event = KEY_LONG_UP;
        else if (roll < 130)
            t.key_event = 2'($urandom_range(0, 2));
        else if (!practice_on)
        begin
            if ($urandom_range(0, 1) != 0)
                t.key_event = ($urandom_range(0, 1) != 0) ? KEY_PRESS : KEY_UP;
        end
        else if (p_phase == P_ANNOUNCE || p_phase == P_SENDING)
        begin
            if ($urandom_range(0, 19) == 0)
                t.key_event = KEY_PRESS;
            if ($urandom_range(0, 4) == 0)
                t.sender_action = ACT_FINISHED;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                t.key_event = tone_now ? KEY_UP : KEY_PRESS;
            else if (pick < 55)
            begin
                t.echo_timed_out = 1'b1;
                t.echo_matched = ($urandom_range(0, 9) < 7);
            end
            else
                t.echo_timed_out = 1'b0;
        end
        return t;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_beat(cwtmc_out_t got);
        cwtmc_out_t want;
        if (tick_results_due.size() == 0)
        begin
            report_mismatch($sformatf("result beat %0h with nothing expected", got));
            return;
        end
        want = tick_results_due.pop_front();
        compare_field("tone_on", 16'(got.tone_on), 16'(want.tone_on));
        compare_field("sender_cmd", 16'(got.sender_cmd), 16'(want.sender_cmd));
        compare_field("capture_clear_before", 16'(got.capture_clear_before),
                      16'(want.capture_clear_before));
        compare_field("capture_advance", 16'(got.capture_advance),
                      16'(want.capture_advance));
        compare_field("capture_push", 16'(got.capture_push), 16'(want.capture_push));
        compare_field("capture_clear_after", 16'(got.capture_clear_after),
                      16'(want.capture_clear_after));
        compare_field("group_chars", 16'(got.group_chars), 16'(want.group_chars));
        compare_field("group_spacing", 16'(got.group_spacing), 16'(want.group_spacing));
        compare_field("random_seed", got.random_seed, want.random_seed);
        compare_field("in_practice", 16'(got.in_practice), 16'(want.in_practice));
    endtask

    task automatic send_tick(cwtmc_in_t t);
        int gap;
        in_valid <= 1'b1;
        in_data <= t;
        valid_hi = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tick_results_due.push_back(advance_controller(t));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(10, 20);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                valid_hi = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop sending and wait until every expected beat has come back
    task automatic drain_results();
        if (valid_hi)
        begin
            in_valid <= 1'b0;
            valid_hi = 1'b0;
        end
        while (tick_results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] spacing, logic [3:0] attempts, logic [3:0] fewest,
                              logic [3:0] most);
        logic [1:0] regs [4];
        logic [3:0] vals [4];
        regs = '{REG_MAX_SPACING, REG_MAX_ATTEMPTS, REG_MIN_CHARS, REG_MAX_CHARS};
        vals = '{spacing, attempts, fewest, most};
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (regs[i])
                REG_MAX_SPACING:  cfg_max_spacing = vals[i];
                REG_MAX_ATTEMPTS: cfg_max_attempts = vals[i][2:0];
                REG_MIN_CHARS:    cfg_min_chars = vals[i][2:0];
                default:          cfg_max_chars = vals[i][2:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, bit toggles);
        for (int i = 0; i < count; i++)
            send_tick(gen_tick(toggles));
    endtask

    task automatic test_straight_key_directed();
        send_tick(tick_of(KEY_NONE, ACT_START_MARK, 1'b0, 1'b0));
        send_tick(tick_of(KEY_NONE, ACT_START_SPACE, 1'b1, 1'b1));
        // key event during the announcement wins over the sender
        send_tick(tick_of(KEY_PRESS, ACT_FINISHED, 1'b0, 1'b0));
        send_tick(tick_of(KEY_UP, ACT_START_MARK, 1'b0, 1'b1));
        send_tick(tick_of(KEY_PRESS, ACT_HOLD, 1'b1, 1'b1));
        send_tick(tick_of(KEY_LONG_UP, ACT_START_SPACE, 1'b1, 1'b0));
    endtask

    task automatic test_practice_directed();
        send_tick(tick_of(KEY_NONE, ACT_START_MARK, 1'b0, 1'b0));
        send_tick(tick_of(KEY_NONE, ACT_FINISHED, 1'b0, 1'b0));
        send_tick(tick_of(KEY_NONE, ACT_START_MARK, 1'b0, 1'b1));
        send_tick(tick_of(KEY_NONE, ACT_FINISHED, 1'b0, 1'b0));
        send_tick(tick_of(KEY_PRESS, ACT_HOLD, 1'b0, 1'b0));
        // timeout together with a key event is not graded
        send_tick(tick_of(KEY_UP, ACT_HOLD, 1'b1, 1'b1));
        send_tick(tick_of(KEY_NONE, ACT_HOLD, 1'b1, 1'b1));
        // keying while the group is sent flushes it
        send_tick(tick_of(KEY_PRESS, ACT_START_MARK, 1'b0, 1'b0));
        send_tick(tick_of(KEY_NONE, ACT_HOLD, 1'b0, 1'b1));
        send_tick(tick_of(KEY_NONE, ACT_FINISHED, 1'b0, 1'b0));
        send_tick(tick_of(KEY_NONE, ACT_HOLD, 1'b0, 1'b1));
        send_tick(tick_of(KEY_NONE, ACT_FINISHED, 1'b0, 1'b0));
        send_tick(tick_of(KEY_NONE, ACT_HOLD, 1'b0, 1'b1));
        send_tick(tick_of(KEY_NONE, ACT_FINISHED, 1'b0, 1'b0));
        // attempts used up: eases and a new group follows
        send_tick(tick_of(KEY_NONE, ACT_START_SPACE, 1'b0, 1'b1));
        send_tick(tick_of(KEY_LONG_UP, ACT_HOLD, 1'b0, 1'b0));
        send_tick(tick_of(KEY_UP, ACT_HOLD, 1'b0, 1'b0));
        send_tick(tick_of(KEY_LONG_UP, ACT_HOLD, 1'b0, 1'b0));
        send_tick(tick_of(KEY_PRESS, ACT_FINISHED, 1'b1, 1'b1));
    endtask

    task automatic test_register_extremes();
        set_config(4'd0, 4'd1, 4'd1, 4'd7);
        run_random(100, 1'b1);
        set_config(4'd15, 4'd7, 4'd1, 4'd7);
        run_random(100, 1'b1);
        // fewest above most, zero attempts and zero characters
        set_config(4'd0, 4'd7, 4'd7, 4'd1);
        run_random(100, 1'b1);
        set_config(4'd1, 4'd0, 4'd0, 4'd0);
        run_random(100, 1'b1);
        set_config(4'd15, 4'd1, 4'd7, 4'd7);
        run_random(100, 1'b1);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            run_random(75, 1'b1);
            drain_results();
            run_random(75, 1'b1);
        end
    endtask

    // default registers with a long release at a steady pace
    task automatic test_default_toggles();
        cwtmc_in_t t;
        set_config(RST_MAX_SPACING, RST_MAX_ATTEMPTS, RST_MIN_CHARS, RST_MAX_CHARS);
        for (int i = 0; i < 80; i++)
        begin
            t = gen_tick(1'b0);
            if (i % 16 == 15)
                t.key_event = KEY_LONG_UP;
            send_tick(t);
        end
    endtask

    // result side: check each beat, stall on a pattern that changes mode now and then
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_beat(out_data);
        if (stall_run <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(16, 96);
        end
        stall_run--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_run % 12 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_straight_key_directed();
        test_practice_directed();
        test_register_extremes();
        test_random_traffic();
        test_default_toggles();
        drain_results();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cwtmc_pkg.sv
hw/rtl/cw_trainer_mode_controller.sv
bench/cw_trainer_mode_controller_tb.sv
